### hw/rtl/lz77d_pkg.sv
// shared types and constants of the lz77 token stream decoder
package lz77d_pkg;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_ZERO   = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;
    localparam logic [1:0] ERR_TRUNC  = 2'd3;

    // one command from the parser to the copy engine
    typedef struct packed {
        logic        is_lit;
        logic [7:0]  lit;
        logic        do_match;
        logic [15:0] offset;
        logic [7:0]  length;
        logic        trunc;
        logic        stream_end;
    } t_cmd;

endpackage

### hw/rtl/lz77d_if.sv
// valid/ready channel interface carrying one payload beat
interface lz77d_if #(
    parameter int W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lz77_token_stream_decoder_unit.sv
// Decodes an lz77 token stream one byte per beat into packed output beats of up to OUT_LANES
// bytes. A two-entry command queue sits between the parser and the copy engine. Once popped,
// a header byte passes the check and end states and a literal the literal, check and end
// states, plus the copy state when the command carries a match. A match copies one byte at a
// time (read address, registered history read, write back) and issues no new read until the
// last byte is written back; this is set by the single read port of the history ram and
// the read-after-write dependency of overlapping copies. Output stalls also hold the engine. No
// clearing pass: history is undefined until written and reads only reach written entries.
module lz77_token_stream_decoder_unit #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int OUT_LANES     = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lz77d_if.sink   i_in,
    lz77d_if.source o_out
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = AW + 1;
    localparam int LW = $clog2(OUT_LANES + 1);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_LIT  = 5'b00010,
        B_CHK  = 5'b00100,
        B_COPY = 5'b01000,
        B_END  = 5'b10000
    } t_bstate;

    // command queue of two entries
    lz77d_pkg::t_cmd r_q [2];
    logic            r_qv [2];
    logic            q_push, q_pop, q_full, q_ready;
    lz77d_pkg::t_cmd q_in;
    logic            cmd_valid;

    // back end
    t_bstate         r_bs;
    lz77d_pkg::t_cmd r_cmd;
    logic [AW-1:0]   r_wp;
    logic [FW-1:0]   r_fill;
    logic [7:0]      r_left;
    logic [AW-1:0]   r_rp;
    logic            r_rd_v;
    logic [LW-1:0]   r_lane;
    logic [63:0]     r_pack;
    logic [1:0]      r_wait;

    logic            r_ov;
    logic [63:0]     r_obytes;
    logic [3:0]      r_ocnt;
    logic            r_olast;
    logic [1:0]      r_oerr;
    logic            o_free;
    logic            ov_load;
    logic            bad_off;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic [AW-1:0]   off_a;
    logic            copy_step;
    logic            lane_full;
    logic [63:0]     pack_next;

    assign q_full  = r_qv[0] && r_qv[1];
    assign q_ready = !q_full;
    assign q_push  = cmd_valid && q_ready;

    lz77d_parser u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in.valid),
        .i_byte(i_in.data[7:0]),
        .i_end(i_in.data[8]),
        .o_ready(i_in.ready),
        .o_cmd_valid(cmd_valid),
        .o_cmd(q_in),
        .i_cmd_ready(q_ready)
    );

    // queue: entry 0 is head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
            r_qv[1] <= 1'b0;
        end else begin
            if (q_pop) begin
                if (q_push) begin
                    r_q[0] <= q_in;
                end else begin
                    r_q[0] <= r_q[1];
                    r_qv[0] <= r_qv[1];
                end
                r_qv[1] <= 1'b0;
            end else if (q_push) begin
                if (r_qv[0]) begin
                    r_q[1] <= q_in;
                    r_qv[1] <= 1'b1;
                end else begin
                    r_q[0] <= q_in;
                    r_qv[0] <= 1'b1;
                end
            end
        end
    end

    lz77d_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_free = !r_ov || o_out.ready;
    assign q_pop  = (r_bs == B_IDLE) && r_qv[0];

    assign off_a = r_cmd.offset[AW-1:0];
    assign bad_off = (r_cmd.offset == 16'd0) || ({1'b0, r_cmd.offset} > 17'(r_fill));

    // one copy in flight at a time: issue read, wait, write and pack
    assign copy_step = (r_bs == B_COPY) && r_rd_v && o_free;
    always_comb begin
        pack_next = r_pack | ({56'd0, ram_rdata} << {r_lane, 3'b000});
    end
    assign lane_full = (r_lane == LW'(OUT_LANES - 1)) || (r_left == 8'd1);

    assign ov_load = ((r_bs == B_LIT) && o_free)
                   || ((r_bs == B_CHK) && r_cmd.do_match && (r_cmd.length != 8'd0)
                       && bad_off && o_free)
                   || (copy_step && lane_full)
                   || ((r_bs == B_END) && r_cmd.trunc && o_free);

    assign ram_we    = ((r_bs == B_LIT) && o_free) || copy_step;
    assign ram_waddr = r_wp;
    assign ram_wdata = (r_bs == B_LIT) ? r_cmd.lit : ram_rdata;
    assign ram_raddr = r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ov_load) begin
            r_ov <= 1'b1;
        end else if (o_out.valid && o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= B_IDLE;
            r_wp <= '0;
            r_fill <= '0;
            r_rd_v <= 1'b0;
            r_wait <= 2'd0;
            r_lane <= '0;
            r_left <= 8'd0;
        end else begin
            unique case (r_bs)
                B_IDLE: begin
                    if (r_qv[0]) begin
                        r_cmd <= r_q[0];
                        r_bs <= r_q[0].is_lit ? B_LIT : B_CHK;
                    end
                end
                B_LIT: begin
                    if (o_free) begin
                        r_obytes <= {56'd0, r_cmd.lit};
                        r_ocnt <= 4'd1;
                        r_oerr <= lz77d_pkg::ERR_NONE;
                        r_olast <= !(r_cmd.do_match && r_cmd.length != 8'd0)
                                   && !r_cmd.trunc;
                        r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                        if (r_fill != FW'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_bs <= B_CHK;
                    end
                end
                B_CHK: begin
                    if (!r_cmd.do_match || r_cmd.length == 8'd0) begin
                        r_bs <= B_END;
                    end else if (o_free) begin
                        if (bad_off) begin
                            r_obytes <= 64'd0;
                            r_ocnt <= 4'd0;
                            r_oerr <= (r_cmd.offset == 16'd0) ? lz77d_pkg::ERR_ZERO
                                                              : lz77d_pkg::ERR_RANGE;
                            r_olast <= !r_cmd.trunc;
                            r_bs <= B_END;
                        end else begin
                            r_left <= r_cmd.length;
                            r_rp <= r_wp - off_a;
                            r_wait <= 2'd0;
                            r_rd_v <= 1'b0;
                            r_lane <= '0;
                            r_pack <= 64'd0;
                            r_bs <= B_COPY;
                        end
                    end
                end
                B_COPY: begin
                    if (!r_rd_v) begin
                        if (r_wait == 2'd1) begin
                            r_rd_v <= 1'b1;
                        end
                        r_wait <= r_wait + 2'd1;
                    end else if (o_free) begin
                        r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                        if (r_fill != FW'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_rp <= (r_rp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_rp + AW'(1);
                        r_rd_v <= 1'b0;
                        r_wait <= 2'd0;
                        r_left <= r_left - 8'd1;
                        if (lane_full) begin
                            r_obytes <= pack_next;
                            r_ocnt <= 4'(r_lane) + 4'd1;
                            r_oerr <= lz77d_pkg::ERR_NONE;
                            r_olast <= (r_left == 8'd1) && !r_cmd.trunc;
                            r_pack <= 64'd0;
                            r_lane <= '0;
                        end else begin
                            r_pack <= pack_next;
                            r_lane <= r_lane + LW'(1);
                        end
                        if (r_left == 8'd1) begin
                            r_bs <= B_END;
                        end
                    end
                end
                B_END: begin
                    if (!r_cmd.trunc || o_free) begin
                        if (r_cmd.trunc) begin
                            r_obytes <= 64'd0;
                            r_ocnt <= 4'd0;
                            r_oerr <= lz77d_pkg::ERR_TRUNC;
                            r_olast <= 1'b1;
                        end
                        if (r_cmd.stream_end) begin
                            r_wp <= '0;
                            r_fill <= '0;
                        end
                        r_bs <= B_IDLE;
                    end
                end
                default: r_bs <= B_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = {r_oerr, r_olast, r_ocnt, r_obytes};

`ifndef SYNTH
    a_busy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs != B_IDLE) |-> !q_pop) else $error("queue popped while busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH)) else $error("history fill overflow");
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oerr != lz77d_pkg::ERR_NONE) |-> (r_ocnt == 4'd0))
        else $error("error beat carries data");
`endif
endmodule

### hw/rtl/lz77d_ram.sv
// generic single-port write, single-port registered read ram
module lz77d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/lz77d_parser.sv
// front end: token header parser producing commands
module lz77d_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    output logic                o_ready,
    output logic                o_cmd_valid,
    output lz77d_pkg::t_cmd     o_cmd,
    input  logic                i_cmd_ready
);
    typedef enum logic [5:0] {
        S_LC0 = 6'b000001,
        S_LC1 = 6'b000010,
        S_OF0 = 6'b000100,
        S_OF1 = 6'b001000,
        S_LEN = 6'b010000,
        S_LIT = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [15:0]     r_lrem, n_lrem;
    logic [15:0]     r_off, n_off;
    logic [7:0]      r_len, n_len;
    lz77d_pkg::t_cmd n_cmd;
    logic            fire;

    assign o_ready     = i_cmd_ready;
    assign fire        = i_valid && i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign o_cmd       = n_cmd;

    always_comb begin
        n_state = r_state;
        n_lrem  = r_lrem;
        n_off   = r_off;
        n_len   = r_len;
        n_cmd.is_lit     = 1'b0;
        n_cmd.lit        = i_byte;
        n_cmd.do_match   = 1'b0;
        n_cmd.offset     = r_off;
        n_cmd.length     = r_len;
        n_cmd.stream_end = i_end;
        unique case (r_state)
            S_LC0: begin
                n_lrem = {8'd0, i_byte};
                n_state = S_LC1;
            end
            S_LC1: begin
                n_lrem = {i_byte, r_lrem[7:0]};
                n_state = S_OF0;
            end
            S_OF0: begin
                n_off = {8'd0, i_byte};
                n_state = S_OF1;
            end
            S_OF1: begin
                n_off = {i_byte, r_off[7:0]};
                n_state = S_LEN;
            end
            S_LEN: begin
                n_len = i_byte;
                n_cmd.length = i_byte;
                if (r_lrem == 16'd0) begin
                    n_cmd.do_match = 1'b1;
                    n_state = S_LC0;
                end else begin
                    n_state = S_LIT;
                end
            end
            S_LIT: begin
                n_cmd.is_lit = 1'b1;
                n_lrem = r_lrem - 16'd1;
                if (r_lrem == 16'd1) begin
                    n_cmd.do_match = 1'b1;
                    n_state = S_LC0;
                end
            end
            default: n_state = S_LC0;
        endcase
        n_cmd.trunc = i_end && (n_state != S_LC0);
        if (i_end) begin
            n_state = S_LC0;
            n_lrem  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LC0;
            r_lrem  <= 16'd0;
            r_off   <= 16'd0;
            r_len   <= 8'd0;
        end else if (fire) begin
            r_state <= n_state;
            r_lrem  <= n_lrem;
            r_off   <= n_off;
            r_len   <= n_len;
        end
    end
endmodule
